/* sv/rate_monotonic_dispatcher_top_assert.svh */
// Assertion macros shared by the dispatcher checker.
`ifndef RATE_MONOTONIC_DISPATCHER_TOP_ASSERT_SVH
`define RATE_MONOTONIC_DISPATCHER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RMD_CHECK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmd check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RMD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmd check failed");

`endif

/* sv/rmd_pkg.sv */
// Types and constants shared by the rate-monotonic dispatcher.
`timescale 1ns / 1ps
package rmd_pkg;

  localparam int MODE_W   = 2;
  localparam int PID_W    = 22;
  localparam int PERIOD_W = 16;
  localparam int CD_W     = 16;
  localparam int ORDER_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG   = 2'd0,
    MODE_DEREG = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_SLEEP = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2
  } slot_state_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REG_SCAN,
    S_DEREG_SCAN,
    S_TICK_UPD,
    S_TICK_SEL,
    S_DECIDE,
    S_DEMOTE_RD,
    S_DEMOTE_WR,
    S_PROMOTE_RD,
    S_PROMOTE_WR,
    S_DONE
  } seq_state_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [PID_W-1:0]    pid;
    logic [PERIOD_W-1:0] period;
    slot_state_t         state;
    logic [CD_W-1:0]     countdown;
    logic [ORDER_W-1:0]  order;
  } entry_t;

  // Memory controls; addresses travel separately since their width follows SLOTS.
  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    entry_t wr_data;
  } mem_ctl_t;

  typedef struct packed {
    logic             dispatched;
    logic             preempted;
    logic             running_valid;
    logic [PID_W-1:0] running_pid;
    status_t          status;
  } result_t;

endpackage

/* sv/rmd_if.sv */
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface rmd_in_if import rmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PID_W-1:0]    task_pid;
  logic [PERIOD_W-1:0] task_period;

  modport source (output valid, output mode, output task_pid, output task_period,
                  input ready);
  modport sink (input valid, input mode, input task_pid, input task_period,
                output ready);
endinterface

interface rmd_out_if import rmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                dispatched;
  logic                preempted;
  logic                running_valid;
  logic [PID_W-1:0]    running_pid;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output dispatched, output preempted,
                  output running_valid, output running_pid, output status,
                  input ready);
  modport sink (input valid, input dispatched, input preempted,
                input running_valid, input running_pid, input status,
                output ready);
endinterface

/* sv/rmd_slot_mem.sv */
// Slot table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rmd_slot_mem import rmd_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  output entry_t           rd_data
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/rmd_seq.sv */
// Sequencer: runs register, deregister, tick and dispatch against the slot table.
`timescale 1ns / 1ps
module rmd_seq import rmd_pkg::*; #(
  parameter int SLOTS = 16,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  mode_t               cmd_mode,
  input  logic [PID_W-1:0]    cmd_pid,
  input  logic [PERIOD_W-1:0] cmd_period,
  output logic                idle,
  output mem_ctl_t            mem_ctl,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    wr_addr,
  input  entry_t              rd_data,
  input  logic                out_free,
  output logic                res_valid,
  output result_t             res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);

  seq_state_t          state, state_next;
  logic [CNT_W-1:0]    issue_idx, issue_idx_next;
  logic                have_data, have_data_next;
  logic [IDX_W-1:0]    data_idx, data_idx_next;
  logic [SLOTS-1:0]    used, used_next;
  logic [ORDER_W-1:0]  order_counter, order_counter_next;
  logic                running_flag, running_flag_next;
  logic [IDX_W-1:0]    running_slot, running_slot_next;
  logic [PID_W-1:0]    running_pid, running_pid_next;
  logic [PERIOD_W-1:0] running_period, running_period_next;
  logic [PID_W-1:0]    pid, pid_next;
  logic [PERIOD_W-1:0] period, period_next;
  logic                fired, fired_next;
  logic                found, found_next;
  logic                dispatched, dispatched_next;
  logic                preempted, preempted_next;
  status_t             status, status_next;
  logic                best_valid, best_valid_next;
  logic [IDX_W-1:0]    best_idx, best_idx_next;
  logic [PERIOD_W-1:0] best_period, best_period_next;
  logic [ORDER_W-1:0]  best_order, best_order_next;
  logic [PID_W-1:0]    best_pid, best_pid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      issue_idx     <= '0;
      have_data     <= 1'b0;
      used          <= '0;
      order_counter <= '0;
      running_flag  <= 1'b0;
      running_slot  <= '0;
      running_pid   <= '0;
      fired         <= 1'b0;
      found         <= 1'b0;
      dispatched    <= 1'b0;
      preempted     <= 1'b0;
      status        <= STAT_OK;
      best_valid    <= 1'b0;
    end else begin
      state         <= state_next;
      issue_idx     <= issue_idx_next;
      have_data     <= have_data_next;
      used          <= used_next;
      order_counter <= order_counter_next;
      running_flag  <= running_flag_next;
      running_slot  <= running_slot_next;
      running_pid   <= running_pid_next;
      fired         <= fired_next;
      found         <= found_next;
      dispatched    <= dispatched_next;
      preempted     <= preempted_next;
      status        <= status_next;
      best_valid    <= best_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data_idx       <= data_idx_next;
    running_period <= running_period_next;
    pid            <= pid_next;
    period         <= period_next;
    best_idx       <= best_idx_next;
    best_period    <= best_period_next;
    best_order     <= best_order_next;
    best_pid       <= best_pid_next;
  end

  always_comb begin
    entry_t           e;
    logic             scan_last;
    logic             fires;
    logic             match;
    logic             better;
    logic [IDX_W-1:0] sidx;

    state_next          = state;
    issue_idx_next      = issue_idx;
    have_data_next      = 1'b0;
    data_idx_next       = issue_idx[IDX_W-1:0];
    used_next           = used;
    order_counter_next  = order_counter;
    running_flag_next   = running_flag;
    running_slot_next   = running_slot;
    running_pid_next    = running_pid;
    running_period_next = running_period;
    pid_next            = pid;
    period_next         = period;
    fired_next          = fired;
    found_next          = found;
    dispatched_next     = dispatched;
    preempted_next      = preempted;
    status_next         = status;
    best_valid_next     = best_valid;
    best_idx_next       = best_idx;
    best_period_next    = best_period;
    best_order_next     = best_order;
    best_pid_next       = best_pid;
    mem_ctl             = '0;
    rd_addr             = '0;
    wr_addr             = '0;
    idle                = 1'b0;
    res_valid           = 1'b0;
    e                   = rd_data;
    fires               = 1'b0;
    match               = 1'b0;
    better              = 1'b0;
    sidx                = issue_idx[IDX_W-1:0];
    scan_last           = have_data && (data_idx == LAST_IDX);

    // The three memory walks issue one read a cycle and handle each read's data in the cycle after it.
    if (state == S_DEREG_SCAN || state == S_TICK_UPD || state == S_TICK_SEL) begin
      if (issue_idx < SLOT_CNT) begin
        mem_ctl.rd_en  = 1'b1;
        rd_addr        = issue_idx[IDX_W-1:0];
        issue_idx_next = issue_idx + CNT_W'(1);
        have_data_next = 1'b1;
      end
    end

    unique case (state)
      S_IDLE: begin
        idle           = 1'b1;
        issue_idx_next = '0;
        if (cmd_valid) begin
          pid_next        = cmd_pid;
          period_next     = cmd_period;
          fired_next      = 1'b0;
          found_next      = 1'b0;
          dispatched_next = 1'b0;
          preempted_next  = 1'b0;
          status_next     = STAT_OK;
          best_valid_next = 1'b0;
          unique case (cmd_mode)
            MODE_REG:   state_next = S_REG_SCAN;
            MODE_DEREG: state_next = S_DEREG_SCAN;
            MODE_TICK:  state_next = S_TICK_UPD;
            MODE_NOP:   state_next = S_DONE;
          endcase
        end
      end

      S_REG_SCAN: begin
        // Lowest free slot takes the new entry.
        priority if (!used[sidx]) begin
          used_next[sidx]        = 1'b1;
          mem_ctl.wr_en          = 1'b1;
          wr_addr                = sidx;
          mem_ctl.wr_data.pid       = pid;
          mem_ctl.wr_data.period    = period;
          mem_ctl.wr_data.state     = ST_SLEEP;
          mem_ctl.wr_data.countdown = period;
          mem_ctl.wr_data.order     = order_counter;
          order_counter_next     = order_counter + ORDER_W'(1);
          status_next            = STAT_OK;
          state_next             = S_DONE;
        end else if (sidx == LAST_IDX) begin
          status_next = STAT_FULL;
          state_next  = S_DONE;
        end else begin
          issue_idx_next = issue_idx + CNT_W'(1);
        end
      end

      S_DEREG_SCAN: begin
        if (have_data) begin
          match = used[data_idx] && (rd_data.pid == pid);
          if (match) begin
            used_next[data_idx] = 1'b0;
            found_next          = 1'b1;
            if (running_flag && running_slot == data_idx) begin
              running_flag_next = 1'b0;
            end
          end
        end
        if (scan_last) begin
          status_next    = (found || match) ? STAT_OK : STAT_NOT_FOUND;
          issue_idx_next = '0;
          have_data_next = 1'b0;
          state_next     = S_DONE;
        end
      end

      S_TICK_UPD: begin
        if (have_data && used[data_idx]) begin
          if (rd_data.countdown[CD_W-1:1] == '0) begin
            fires       = 1'b1;
            e.countdown = rd_data.period;
            e.state     = ST_READY;
            fired_next  = 1'b1;
            if (running_flag && running_slot == data_idx) begin
              running_flag_next = 1'b0;
            end
          end else begin
            e.countdown = rd_data.countdown - CD_W'(1);
          end
          mem_ctl.wr_en   = 1'b1;
          wr_addr         = data_idx;
          mem_ctl.wr_data = e;
        end
        if (scan_last) begin
          issue_idx_next = '0;
          have_data_next = 1'b0;
          state_next     = (fired || fires) ? S_TICK_SEL : S_DONE;
        end
      end

      S_TICK_SEL: begin
        if (have_data && used[data_idx] && rd_data.state == ST_READY) begin
          // Smaller period wins; on equal periods the later registration wins.
          better = !best_valid || (rd_data.period < best_period) ||
                   ((rd_data.period == best_period) && (rd_data.order > best_order));
          if (better) begin
            best_valid_next  = 1'b1;
            best_idx_next    = data_idx;
            best_period_next = rd_data.period;
            best_order_next  = rd_data.order;
            best_pid_next    = rd_data.pid;
          end
        end
        if (scan_last) begin
          issue_idx_next = '0;
          have_data_next = 1'b0;
          state_next     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        priority if (!best_valid) begin
          state_next = S_DONE;
        end else if (running_flag && running_period < best_period) begin
          state_next = S_DONE;
        end else if (running_flag) begin
          preempted_next = 1'b1;
          state_next     = S_DEMOTE_RD;
        end else begin
          state_next = S_PROMOTE_RD;
        end
      end

      S_DEMOTE_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = running_slot;
        state_next    = S_DEMOTE_WR;
      end

      S_DEMOTE_WR: begin
        e.state         = ST_READY;
        mem_ctl.wr_en   = 1'b1;
        wr_addr         = running_slot;
        mem_ctl.wr_data = e;
        state_next      = S_PROMOTE_RD;
      end

      S_PROMOTE_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = best_idx;
        state_next    = S_PROMOTE_WR;
      end

      S_PROMOTE_WR: begin
        e.state             = ST_RUN;
        mem_ctl.wr_en       = 1'b1;
        wr_addr             = best_idx;
        mem_ctl.wr_data     = e;
        running_flag_next   = 1'b1;
        running_slot_next   = best_idx;
        running_pid_next    = best_pid;
        running_period_next = best_period;
        dispatched_next     = 1'b1;
        state_next          = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.dispatched    = dispatched;
    res.preempted     = preempted;
    res.running_valid = running_flag;
    res.running_pid   = running_flag ? running_pid : '0;
    res.status        = status;
  end

endmodule

/* sv/rate_monotonic_dispatcher_top.sv */
// Register scans the valid bits for the lowest free slot, deregister walks every slot
// and a tick walks every slot once, then again to pick a task if any countdown fired.
// One command at a time; the sequencer is ready for the next in the cycle after the
// result is registered. The tick's passes over the slot memory read one entry a cycle.
// Reset clears the slot valid bits, the order counter and the running task at once;
// the slot memory is not cleared, so commands are taken right after reset.
`timescale 1ns / 1ps
module rate_monotonic_dispatcher_top import rmd_pkg::*; #(
  parameter int SLOTS = 16
) (
  input logic      clk,
  input logic      rst,
  rmd_in_if.sink   cmd,
  rmd_out_if.source rsp
);

  localparam int IDX_W = $clog2(SLOTS);

  // The sequencer owns the valid bits and the running-task registers; every
  // other per-slot field lives in the slot memory and is walked one entry a
  // cycle with a read-modify-write pipeline.
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           rd_data;
  logic             idle;
  logic             res_valid;
  result_t          res;
  logic             out_free;

  // Output register: a finished result waits here until its transfer, while
  // the sequencer is already free to take the next command.
  logic             rsp_valid;
  result_t          rsp_data;

  assign out_free  = !rsp_valid || rsp.ready;
  // No command transfer is offered while reset is held.
  assign cmd.ready = idle && !rst;

  rmd_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_mode   (mode_t'(cmd.mode)),
    .cmd_pid    (cmd.task_pid),
    .cmd_period (cmd.task_period),
    .idle       (idle),
    .mem_ctl    (mem_ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .rd_data    (rd_data),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  rmd_slot_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.dispatched    = rsp_data.dispatched;
  assign rsp.preempted     = rsp_data.preempted;
  assign rsp.running_valid = rsp_data.running_valid;
  assign rsp.running_pid   = rsp_data.running_pid;
  assign rsp.status        = rsp_data.status;

endmodule

/* sv/rmd_checker.sv */
// Port-level checker for the dispatcher and its bind to the top level.
`timescale 1ns / 1ps
`include "rate_monotonic_dispatcher_top_assert.svh"
module rmd_checker import rmd_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic                dispatched,
  input logic                preempted,
  input logic                running_valid,
  input logic [PID_W-1:0]    running_pid,
  input logic [STATUS_W-1:0] status
);

  `RMD_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(running_pid) && $stable(status))
  `RMD_CHECK_NOW(a_idle_pid, rsp_valid && !running_valid, running_pid == '0)
  `RMD_CHECK_NOW(a_dispatch_runs, rsp_valid && dispatched, running_valid && status == STAT_OK)
  `RMD_CHECK_NOW(a_preempt_dispatch, rsp_valid && preempted, dispatched)

endmodule

bind rate_monotonic_dispatcher_top rmd_checker u_rmd_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .dispatched    (rsp.dispatched),
  .preempted     (rsp.preempted),
  .running_valid (rsp.running_valid),
  .running_pid   (rsp.running_pid),
  .status        (rsp.status)
);

/* test/tb_rate_monotonic_dispatcher_top.sv */
// Self-checking testbench for the rate-monotonic dispatcher: directed table plus random traffic.
`timescale 1ns / 1ps
module tb_rate_monotonic_dispatcher_top;
  import rmd_pkg::*;

  localparam int SLOTS = 16;
  // Directed rows, then random commands; together about 1100 transfers.
  localparam int NDIR = 24;
  localparam int N_RANDOM = 1076;
  localparam int N_TOTAL = NDIR + N_RANDOM;
  // The longest command is a tick; the tail adds margin.
  localparam int DRAIN_CYCLES = 2 * SLOTS + 24;
  // One long stretch where the result side refuses transfers.
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT = NDIR + 500;
  // The slowest correct run, the hold included, stays under 1 ms at 10 ns per cycle;
  // the watchdog allows four times that.
  localparam int LIMIT_NS = 4_000_000;

  typedef struct packed {
    mode_t               mode;
    logic [PID_W-1:0]    pid;
    logic [PERIOD_W-1:0] period;
  } cmd_t;

  // A directed row carries the command and, where it is obvious, the result it must give.
  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t R_IDLE = '{1'b0, 1'b0, 1'b0, 22'h000000, STAT_OK};
  localparam result_t R_MISS = '{1'b0, 1'b0, 1'b0, 22'h000000, STAT_NOT_FOUND};

  // Rows without a typed result are checked against the predictor.
  localparam dir_row_t DIRECTED [NDIR] = '{
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b1, R_IDLE}, // tick with an empty table
    '{'{MODE_DEREG, 22'h3FFFFF, 16'h0000}, 1'b1, R_MISS}, // unknown pid
    '{'{MODE_NOP,   22'h3FFFFF, 16'hFFFF}, 1'b1, R_IDLE}, // unused mode does nothing
    '{'{MODE_REG,   22'h3FFFFF, 16'hFFFF}, 1'b1, R_IDLE}, // largest pid and period
    '{'{MODE_REG,   22'h000000, 16'h0001}, 1'b1, R_IDLE}, // smallest pid, period one
    '{'{MODE_REG,   22'h000005, 16'h0000}, 1'b1, R_IDLE}, // zero period
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE}, // zero-period task wins
    '{'{MODE_TICK,  22'h3FFFFF, 16'hFFFF}, 1'b0, R_IDLE}, // running task fires again
    '{'{MODE_REG,   22'h000007, 16'h0000}, 1'b0, R_IDLE}, // same period, newer entry
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE}, // tie goes to the newer entry
    '{'{MODE_DEREG, 22'h000007, 16'h0000}, 1'b1, R_IDLE}, // removes the running task
    '{'{MODE_REG,   22'h000009, 16'h0002}, 1'b1, R_IDLE}, // reuses the freed slot
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE},
    '{'{MODE_DEREG, 22'h000005, 16'h0000}, 1'b1, R_IDLE},
    '{'{MODE_DEREG, 22'h000000, 16'h0000}, 1'b1, R_IDLE},
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE},
    '{'{MODE_REG,   22'h155555, 16'h0001}, 1'b0, R_IDLE},
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE}, // shorter period preempts
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE},
    '{'{MODE_DEREG, 22'h155555, 16'h0000}, 1'b1, R_IDLE},
    '{'{MODE_REG,   22'h2AAAAA, 16'h0003}, 1'b0, R_IDLE},
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE}, // nothing fires, no dispatch
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE},
    '{'{MODE_TICK,  22'h000000, 16'h0000}, 1'b0, R_IDLE}  // shorter running task is kept
  };

  logic clk;
  logic rst;
  bit   hold_go = 1'b0;
  bit   quiet = 1'b0;
  int   fail_cnt = 0;

  rmd_in_if  cmd_ch ();
  rmd_out_if rsp_ch ();

  rate_monotonic_dispatcher_top #(.SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the task table, kept in step with every accepted command.
  logic                tbl_used   [SLOTS];
  logic [PID_W-1:0]    tbl_pid    [SLOTS];
  logic [PERIOD_W-1:0] tbl_period [SLOTS];
  slot_state_t         tbl_state  [SLOTS];
  logic [CD_W-1:0]     tbl_cd     [SLOTS];
  logic [ORDER_W-1:0]  tbl_order  [SLOTS];
  logic [ORDER_W-1:0]  next_order;
  int                  run_idx;
  bit                  run_on;

  // Results still owed by the block, oldest first.
  result_t sched_outcomes [$];

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic result_t schedule_step(cmd_t c);
    result_t r;
    bit      fired;
    bit      found;
    int      best;
    r = '0;
    r.status = STAT_OK;
    case (c.mode)
      MODE_REG: begin
        // The lowest free slot takes the new entry; a full table changes nothing.
        r.status = STAT_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_pid[i] = c.pid;
            tbl_period[i] = c.period;
            tbl_state[i] = ST_SLEEP;
            tbl_cd[i] = c.period;
            tbl_order[i] = next_order;
            next_order = next_order + 1'b1;
            r.status = STAT_OK;
            break;
          end
        end
      end
      MODE_DEREG: begin
        // Every entry with the pid goes; dropping the running one leaves nothing running.
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[i] && tbl_pid[i] == c.pid) begin
            tbl_used[i] = 1'b0;
            found = 1'b1;
            if (run_on && run_idx == i) run_on = 1'b0;
          end
        end
        r.status = found ? STAT_OK : STAT_NOT_FOUND;
      end
      MODE_TICK: begin
        // Countdowns of one or zero fire and reload; a firing running task turns ready.
        fired = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_used[i]) begin
            if (tbl_cd[i] <= 1) begin
              tbl_cd[i] = tbl_period[i];
              tbl_state[i] = ST_READY;
              fired = 1'b1;
              if (run_on && run_idx == i) run_on = 1'b0;
            end else begin
              tbl_cd[i] = tbl_cd[i] - 1'b1;
            end
          end
        end
        if (fired) begin
          // Shortest period wins; on equal periods the later registration wins.
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_used[i] && tbl_state[i] == ST_READY) begin
              if (best < 0) begin
                best = i;
              end else if (tbl_period[i] < tbl_period[best] ||
                           (tbl_period[i] == tbl_period[best] &&
                            tbl_order[i] > tbl_order[best])) begin
                best = i;
              end
            end
          end
          if (best >= 0) begin
            if (!(run_on && tbl_period[run_idx] < tbl_period[best])) begin
              if (run_on) begin
                tbl_state[run_idx] = ST_READY;
                r.preempted = 1'b1;
              end
              run_idx = best;
              run_on = 1'b1;
              tbl_state[best] = ST_RUN;
              r.dispatched = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.running_valid = run_on;
    r.running_pid = run_on ? tbl_pid[run_idx] : '0;
    return r;
  endfunction

  // Command side: directed rows first, then random traffic. Each transfer is
  // predicted at the edge where it is accepted.
  initial begin : cmd_side
    cmd_t    c;
    result_t want;
    int      gap;
    int      fill_left;
    int      pick;
    int      live [$];

    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.mode = MODE_NOP;
    cmd_ch.task_pid = '0;
    cmd_ch.task_period = '0;
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
    next_order = '0;
    run_idx = 0;
    run_on = 1'b0;
    // The first random command opens a burst of registers that overfills the table.
    fill_left = SLOTS + 2;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < N_TOTAL; k++) begin
      if (k < NDIR) begin
        c = DIRECTED[k].cmd;
      end else begin
        live.delete();
        for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) live.push_back(i);
        if (fill_left == 0 && $urandom_range(0, 149) == 0) fill_left = SLOTS + 2;
        // Mostly a small pid pool so that removals hit, with full-range pids now and
        // then; periods are mostly short so that ticks keep firing.
        c.pid = ($urandom_range(0, 7) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(0, 11));
        c.period = ($urandom_range(0, 15) == 0) ? PERIOD_W'($urandom_range(1, 65535)) :
                                                  PERIOD_W'($urandom_range(1, 6));
        pick = $urandom_range(0, 99);
        if (fill_left > 0) begin
          c.mode = MODE_REG;
          fill_left--;
        end else if (pick < ((live.size() < 4) ? 45 : 22)) begin
          c.mode = MODE_REG;
        end else if (pick < 38) begin
          c.mode = MODE_DEREG;
          if (live.size() > 0 && $urandom_range(0, 3) != 0)
            c.pid = tbl_pid[live[$urandom_range(0, live.size() - 1)]];
        end else if (pick < 99) begin
          c.mode = MODE_TICK;
        end else begin
          c.mode = MODE_NOP;
        end
      end

      if (k == HOLD_AT) hold_go <= 1'b1;
      if (k == N_TOTAL - 100) quiet <= 1'b1;

      // Occasional idle burst before offering the next command.
      gap = (quiet || $urandom_range(0, 7) != 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cmd_ch.valid <= 1'b1;
      cmd_ch.mode <= c.mode;
      cmd_ch.task_pid <= c.pid;
      cmd_ch.task_period <= c.period;
      do @(posedge clk); while (cmd_ch.ready !== 1'b1);

      want = schedule_step(c);
      if (k < NDIR && DIRECTED[k].typed) want = DIRECTED[k].want;
      sched_outcomes.push_back(want);
    end
    cmd_ch.valid <= 1'b0;

    // Let every owed result arrive, then watch a while longer for stray transfers.
    while (sched_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && sched_outcomes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold while commands keep coming so
  // that the block backs up into its command port, and no stalls at the end.
  initial begin : rsp_side
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (sched_outcomes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result transfer with nothing owed (pid %h status %0d)",
                   $realtime, rsp_ch.running_pid, rsp_ch.status);
      end else begin
        want = sched_outcomes.pop_front();
        if (rsp_ch.dispatched !== want.dispatched || rsp_ch.preempted !== want.preempted ||
            rsp_ch.running_valid !== want.running_valid ||
            rsp_ch.running_pid !== want.running_pid || rsp_ch.status !== want.status) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: mismatch, expected disp %0b pre %0b run %0b pid %h st %0d,",
                     $realtime, want.dispatched, want.preempted, want.running_valid,
                     want.running_pid, want.status,
                     " got disp %0b pre %0b run %0b pid %h st %0d",
                     rsp_ch.dispatched, rsp_ch.preempted, rsp_ch.running_valid,
                     rsp_ch.running_pid, rsp_ch.status);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/rmd_pkg.sv
sv/rmd_if.sv
sv/rmd_slot_mem.sv
sv/rmd_seq.sv
sv/rate_monotonic_dispatcher_top.sv
sv/rmd_checker.sv
test/tb_rate_monotonic_dispatcher_top.sv
